// ===== design/wcm_pkg.sv =====
// shared constants, types and config register codes for the column mixer
package wcm_pkg;

  localparam int NUM_CHANNELS = 4;    // channels that take part, 2..4
  localparam int FIELD_CH     = 4;    // channel fields on the ports
  localparam int SW           = 16;   // sample width
  localparam int DNW          = 24;   // down output width
  localparam int TW           = 32;   // per channel term
  localparam int PW           = 34;   // prefix sum of terms
  localparam int CW           = 18;   // per channel weight contribution
  localparam int WW           = 20;   // prefix sum of weights
  localparam int NW           = 33;   // dividend magnitude and quotient
  localparam int DVW          = 18;   // divisor magnitude
  localparam int BPS          = 3;    // quotient bits per divider stage
  localparam int NDIV         = (NW + BPS - 1) / BPS;
  localparam int NSTG         = NDIV + 5;

  localparam int IN_TDATA_W   = 136;
  localparam int OUT_TDATA_W  = 160;
  localparam int SIDEW        = FIELD_CH * SW;

  localparam logic signed [DNW-1:0] DOWN_MAX = {1'b0, {(DNW-1){1'b1}}};
  localparam logic signed [DNW-1:0] DOWN_MIN = {1'b1, {(DNW-1){1'b0}}};

  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] CFG_AVERAGE  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_WEIGHTED = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_NEG_OK   = 2'd2;

  typedef logic signed [PW-1:0] sum_t;
  typedef logic signed [WW-1:0] wsum_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } lane_flags_t;

endpackage

// ===== design/wcm_div_stage.sv =====
// one registered step of the restoring divider, three quotient bits per step
module wcm_div_stage (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [wcm_pkg::DVW-1:0]       rem_i,
  input  logic [wcm_pkg::NW-1:0]        quo_i,
  input  logic [wcm_pkg::DVW-1:0]       dvs_i,
  output logic [wcm_pkg::DVW-1:0]       rem_o,
  output logic [wcm_pkg::NW-1:0]        quo_o,
  output logic [wcm_pkg::DVW-1:0]       dvs_o
);

  logic [wcm_pkg::DVW-1:0] rem_d, rem_q;
  logic [wcm_pkg::NW-1:0]  quo_d, quo_q;
  logic [wcm_pkg::DVW-1:0] dvs_q;

  always_comb begin
    logic [wcm_pkg::DVW:0]  r;
    logic [wcm_pkg::NW-1:0] n;
    r = {1'b0, rem_i};
    n = quo_i;
    for (int b = 0; b < wcm_pkg::BPS; b++) begin
      r = {r[wcm_pkg::DVW-1:0], n[wcm_pkg::NW-1]};
      n = {n[wcm_pkg::NW-2:0], 1'b0};
      if (r >= {1'b0, dvs_i}) begin
        r    = r - {1'b0, dvs_i};
        n[0] = 1'b1;
      end
    end
    rem_d = r[wcm_pkg::DVW-1:0];
    quo_d = n;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      dvs_q <= dvs_i;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign dvs_o = dvs_q;

endmodule

// ===== design/weighted_column_mixer_unit.sv =====
// top level of the weighted column mixer: terms, prefix sums, divider, saturation
//
// channel   dir  port group                fields (lowest bit up)
// s_axis    in   tvalid tready tdata       signal_0..3, upstream_0..3, upstream_connected
// m_axis    out  tvalid tready tdata       side_0..3, down_0..3
// cfg       in   cfg_we cfg_index cfg_data average, weighted, negative weights
//
// one item per cycle while the output is not stalled; 4 front stages, one stage per
// three quotient bits of the restoring divider, one output stage
// every item goes through the divider: divisor is the running weight in
// average mode, 2048 in plain weighted mode, 1 in plain additive mode
// each stage has its own valid bit and advances when it is empty or the next
// one moves, so bubbles squeeze out and a stall drops or repeats nothing
// reset clears the valid bits and config registers only
module weighted_column_mixer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // signal_0..3, upstream_0..3, upstream_connected, zero pad
  input  logic [wcm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // side_0..3, down_0..3
  output logic [wcm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [wcm_pkg::CFG_IW-1:0]         cfg_index_i,
  input  logic                               cfg_data_i
);

  localparam int L = wcm_pkg::FIELD_CH;
  localparam int DS = 4;                      // first divider stage
  localparam int OS = wcm_pkg::NSTG - 1;      // output stage

  // config registers
  logic avg_q, wtd_q, negok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q   <= 1'b0;
      wtd_q   <= 1'b0;
      negok_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wcm_pkg::CFG_AVERAGE:  avg_q   <= cfg_data_i;
        wcm_pkg::CFG_WEIGHTED: wtd_q   <= cfg_data_i;
        wcm_pkg::CFG_NEG_OK:   negok_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid chain with per stage advance
  logic [wcm_pkg::NSTG-1:0] valid_q;
  logic [wcm_pkg::NSTG-1:0] en;

  always_comb begin
    en[OS] = !valid_q[OS] || m_axis_tready;
    for (int k = OS - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < wcm_pkg::NSTG; k++) begin
        if (en[k]) begin
          valid_q[k] <= (k == 0) ? s_axis_tvalid : valid_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid_q[OS];

  // side samples ride along every stage
  logic [wcm_pkg::SIDEW-1:0] side_q [wcm_pkg::NSTG];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < wcm_pkg::NSTG; k++) begin
      if (en[k]) begin
        side_q[k] <= (k == 0) ? s_axis_tdata[wcm_pkg::SIDEW-1:0] : side_q[k-1];
      end
    end
  end

  // stage 0: per channel term and weight contribution
  logic signed [wcm_pkg::TW-1:0] term_d [L];
  logic signed [wcm_pkg::CW-1:0] wc_d   [L];
  logic signed [wcm_pkg::TW-1:0] term_q [L];
  logic signed [wcm_pkg::CW-1:0] wc_q   [L];
  logic [L-1:0] conn;

  assign conn = s_axis_tdata[2*wcm_pkg::SIDEW +: L];

  for (genvar c = 0; c < L; c++) begin : g_term
    logic signed [wcm_pkg::SW-1:0] s, u;
    logic signed [wcm_pkg::TW-1:0] prod;
    logic signed [wcm_pkg::SW:0]   sm;
    logic signed [wcm_pkg::CW-1:0] u_w;

    assign s    = s_axis_tdata[c*wcm_pkg::SW +: wcm_pkg::SW];
    assign u    = conn[c] ? s_axis_tdata[wcm_pkg::SIDEW + c*wcm_pkg::SW +: wcm_pkg::SW] : '0;
    assign prod = s * u;
    assign sm   = s + u;
    assign u_w  = wcm_pkg::CW'(u);

    always_comb begin
      if (c >= wcm_pkg::NUM_CHANNELS) begin
        term_d[c] = '0;
        wc_d[c]   = '0;
      end else if (wtd_q) begin
        term_d[c] = prod;
        wc_d[c]   = (negok_q || !u_w[wcm_pkg::CW-1]) ? u_w : -u_w;
      end else begin
        term_d[c] = wcm_pkg::TW'(sm);
        wc_d[c]   = wcm_pkg::CW'({1'b0, u != '0}) + wcm_pkg::CW'({1'b0, s != '0});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      term_q <= term_d;
      wc_q   <= wc_d;
    end
  end

  // stages 1 and 2: prefix sums in two halves
  wcm_pkg::sum_t  pa_q [L];
  wcm_pkg::wsum_t wa_q [L];
  wcm_pkg::sum_t  pb_q [L];
  wcm_pkg::wsum_t wb_q [L];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pa_q[0] <= wcm_pkg::PW'(term_q[0]);
      pa_q[1] <= wcm_pkg::PW'(term_q[0]) + wcm_pkg::PW'(term_q[1]);
      pa_q[2] <= wcm_pkg::PW'(term_q[2]);
      pa_q[3] <= wcm_pkg::PW'(term_q[2]) + wcm_pkg::PW'(term_q[3]);
      wa_q[0] <= wcm_pkg::WW'(wc_q[0]);
      wa_q[1] <= wcm_pkg::WW'(wc_q[0]) + wcm_pkg::WW'(wc_q[1]);
      wa_q[2] <= wcm_pkg::WW'(wc_q[2]);
      wa_q[3] <= wcm_pkg::WW'(wc_q[2]) + wcm_pkg::WW'(wc_q[3]);
    end
    if (en[2]) begin
      pb_q[0] <= pa_q[0];
      pb_q[1] <= pa_q[1];
      pb_q[2] <= pa_q[1] + pa_q[2];
      pb_q[3] <= pa_q[1] + pa_q[3];
      wb_q[0] <= wa_q[0];
      wb_q[1] <= wa_q[1];
      wb_q[2] <= wa_q[1] + wa_q[2];
      wb_q[3] <= wa_q[1] + wa_q[3];
    end
  end

  // stage 3: sign and magnitude, divisor select
  logic [wcm_pkg::NW-1:0]  dv_quo [wcm_pkg::NDIV+1][L];
  logic [wcm_pkg::DVW-1:0] dv_rem [wcm_pkg::NDIV+1][L];
  logic [wcm_pkg::DVW-1:0] dv_dvs [wcm_pkg::NDIV+1][L];
  wcm_pkg::lane_flags_t    flg_q  [3:OS-1][L];

  for (genvar c = 0; c < L; c++) begin : g_prep
    logic [wcm_pkg::NW-1:0]  mag_q;
    logic [wcm_pkg::DVW-1:0] dvs_q;
    logic                    tneg, wneg;
    wcm_pkg::sum_t           pneg;
    wcm_pkg::wsum_t          wabs;

    assign tneg = pb_q[c][wcm_pkg::PW-1];
    assign wneg = wb_q[c][wcm_pkg::WW-1];
    assign pneg = -pb_q[c];
    assign wabs = wneg ? -wb_q[c] : wb_q[c];

    always_ff @(posedge clk_i) begin
      if (en[3]) begin
        mag_q <= tneg ? pneg[wcm_pkg::NW-1:0] : pb_q[c][wcm_pkg::NW-1:0];
        if (avg_q) begin
          dvs_q <= wabs[wcm_pkg::DVW-1:0];
        end else if (wtd_q) begin
          dvs_q <= wcm_pkg::DVW'(2048);
        end else begin
          dvs_q <= wcm_pkg::DVW'(1);
        end
        flg_q[3][c].neg  <= tneg ^ (avg_q && wneg);
        flg_q[3][c].zero <= avg_q && (wb_q[c] == '0);
      end
    end

    assign dv_quo[0][c] = mag_q;
    assign dv_rem[0][c] = '0;
    assign dv_dvs[0][c] = dvs_q;
  end

  // divider stages
  for (genvar k = 0; k < wcm_pkg::NDIV; k++) begin : g_div
    for (genvar c = 0; c < L; c++) begin : g_lane
      wcm_div_stage u_stage (
        .clk_i (clk_i),
        .en_i  (en[DS+k]),
        .rem_i (dv_rem[k][c]),
        .quo_i (dv_quo[k][c]),
        .dvs_i (dv_dvs[k][c]),
        .rem_o (dv_rem[k+1][c]),
        .quo_o (dv_quo[k+1][c]),
        .dvs_o (dv_dvs[k+1][c])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = DS; k < OS; k++) begin
      if (en[k]) begin
        flg_q[k] <= flg_q[k-1];
      end
    end
  end

  // output stage: sign, saturation, zero weight
  logic signed [wcm_pkg::DNW-1:0] down_d [L];
  logic signed [wcm_pkg::DNW-1:0] down_q [L];

  for (genvar c = 0; c < L; c++) begin : g_sat
    logic [wcm_pkg::NW-1:0] q;
    assign q = dv_quo[wcm_pkg::NDIV][c];
    always_comb begin
      priority if (flg_q[OS-1][c].zero) begin
        down_d[c] = '0;
      end else if (flg_q[OS-1][c].neg) begin
        down_d[c] = (q > wcm_pkg::NW'(unsigned'(1) << (wcm_pkg::DNW - 1)))
                    ? wcm_pkg::DOWN_MIN : -q[wcm_pkg::DNW-1:0];
      end else begin
        down_d[c] = (q > wcm_pkg::NW'(wcm_pkg::DOWN_MAX))
                    ? wcm_pkg::DOWN_MAX : q[wcm_pkg::DNW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OS]) begin
      down_q <= down_d;
    end
  end

  // result packing; channels beyond the active count read zero
  for (genvar c = 0; c < L; c++) begin : g_out
    if (c < wcm_pkg::NUM_CHANNELS) begin : g_on
      assign m_axis_tdata[c*wcm_pkg::SW +: wcm_pkg::SW] =
        side_q[OS][c*wcm_pkg::SW +: wcm_pkg::SW];
      assign m_axis_tdata[wcm_pkg::SIDEW + c*wcm_pkg::DNW +: wcm_pkg::DNW] = down_q[c];
    end else begin : g_off
      assign m_axis_tdata[c*wcm_pkg::SW +: wcm_pkg::SW] = '0;
      assign m_axis_tdata[wcm_pkg::SIDEW + c*wcm_pkg::DNW +: wcm_pkg::DNW] = '0;
    end
  end

endmodule

// ===== design/wcm_checker.sv =====
// port level checks on the column mixer and their binding
module wcm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [wcm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a taker downstream means the whole pipe moves
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled with output free");

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without backpressure");

endmodule

bind weighted_column_mixer_unit wcm_checker u_wcm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
